/* rtl/core/tournament_branch_predictor_assert.svh */
// Assertion macros for the tournament branch predictor.
// Used by the top level; expects clk and rst in scope.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define TBP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tournament predictor check failed");

// Next-cycle implication, checked out of reset
`define TBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tournament predictor check failed");

`endif

/* rtl/core/tbp_pkg.sv */
// Shared types and constants for the tournament branch predictor.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package tbp_pkg;

  // Default table index widths (log2 of table depths)
  localparam int GH_MAX_DEF = 12;
  localparam int LH_MAX_DEF = 12;
  localparam int PC_MAX_DEF = 12;

  // Configuration register file
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GH_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LH_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PC_BITS = 2'd2;
  localparam logic [CFG_W-1:0] GH_BITS_RST = 4'd9;
  localparam logic [CFG_W-1:0] LH_BITS_RST = 4'd10;
  localparam logic [CFG_W-1:0] PC_BITS_RST = 4'd10;

  // Two-bit saturating counters
  localparam int CTR_W = 2;
  localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_en;
    logic accept_pred;
    logic accept_train;
    logic cap_li;
    logic load_out;
    logic write_back;
  } tbp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } tbp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/tbp_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies; instanced for every predictor table.
`default_nettype none

module tbp_ram #(
  parameter int WIDTH  = 2,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* rtl/core/tbp_ctrl.sv */
// Controller FSM for the tournament branch predictor.
// Depends on tbp_pkg; drives commands into tbp_dp.
`default_nettype none

module tbp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire logic              req_type,
  output logic                   req_stall,
  input  wire tbp_pkg::tbp_sts_t sts,
  output tbp_pkg::tbp_cmd_t      cmd
);
  import tbp_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_PRD_A  = 3'd2;
  localparam logic [2:0] S_PRD_B  = 3'd3;
  localparam logic [2:0] S_PRD_C  = 3'd4;
  localparam logic [2:0] S_TRN_RD = 3'd5;
  localparam logic [2:0] S_TRN_WR = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // Input beat only taken when idle
  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd              = '0;
    cmd.clear_en     = (state == S_CLEAR);
    cmd.accept_pred  = (state == S_IDLE) && req_valid && !req_type;
    cmd.accept_train = (state == S_IDLE) && req_valid && req_type;
    cmd.cap_li       = (state == S_PRD_B);
    cmd.load_out     = (state == S_PRD_C) && sts.out_free;
    cmd.write_back   = (state == S_TRN_WR);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.accept_pred) state_next = S_PRD_A;
        else if (cmd.accept_train) state_next = S_TRN_RD;
      end
      S_PRD_A:  state_next = S_PRD_B;
      S_PRD_B:  state_next = S_PRD_C;
      S_PRD_C: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      S_TRN_RD: state_next = S_TRN_WR;
      S_TRN_WR: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tbp_dp.sv */
// Datapath for the tournament branch predictor: config, tables, latches, output.
// Depends on tbp_pkg and tbp_ram; commanded by tbp_ctrl.
`default_nettype none

module tbp_dp #(
  parameter int GH_MAX = tbp_pkg::GH_MAX_DEF,
  parameter int LH_MAX = tbp_pkg::LH_MAX_DEF,
  parameter int PC_MAX = tbp_pkg::PC_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tbp_pkg::tbp_cmd_t             cmd,
  output tbp_pkg::tbp_sts_t                  sts,
  input  wire logic [31:0]                   pc,
  input  wire logic                          outcome,
  input  wire logic                          cfg_we,
  input  wire logic [tbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tbp_pkg::CFG_W-1:0]     cfg_data,
  output logic                               resp_valid,
  input  wire logic                          resp_stall,
  output logic                               prediction
);
  import tbp_pkg::*;

  localparam int CLR_W = (GH_MAX > LH_MAX) ? ((GH_MAX > PC_MAX) ? GH_MAX : PC_MAX)
                                           : ((LH_MAX > PC_MAX) ? LH_MAX : PC_MAX);

  function automatic logic [CTR_W-1:0] sat_move(input logic [CTR_W-1:0] c, input logic up);
    if (up) return (c == CTR_MAX) ? c : c + 2'd1;
    return (c == '0) ? c : c - 2'd1;
  endfunction

  // Configuration registers
  logic [CFG_W-1:0] gh_bits;
  logic [CFG_W-1:0] lh_bits;
  logic [CFG_W-1:0] pc_bits;

  // Architectural and latched state
  logic [GH_MAX-1:0] global_history;
  logic [GH_MAX-1:0] lat_gi;
  logic [PC_MAX-1:0] lat_ls;
  logic [LH_MAX-1:0] lat_li;
  logic              lat_gg;
  logic              lat_lg;
  logic              outcome_q;
  logic              gg_q;
  logic              ch_q;
  logic [CLR_W-1:0]  clr_cnt;

  // Masks: width clamped to [1, MAX]
  logic [GH_MAX-1:0] gmask;
  logic [LH_MAX-1:0] lmask;
  logic [PC_MAX-1:0] pmask;

  always_comb begin
    for (int i = 0; i < GH_MAX; i++) gmask[i] = (i == 0) || (i < int'(gh_bits));
    for (int i = 0; i < LH_MAX; i++) lmask[i] = (i == 0) || (i < int'(lh_bits));
    for (int i = 0; i < PC_MAX; i++) pmask[i] = (i == 0) || (i < int'(pc_bits));
  end

  // RAM ports
  logic [CTR_W-1:0]  gctr_rd, chs_rd, lctr_rd;
  logic [LH_MAX-1:0] lhist_rd;
  logic [CTR_W-1:0]  gctr_wd, chs_wd, lctr_wd;
  logic [LH_MAX-1:0] lhist_wd;
  logic              gctr_we, chs_we, lctr_we, lhist_we;
  logic [GH_MAX-1:0] g_addr;
  logic [PC_MAX-1:0] ls_addr;
  logic [LH_MAX-1:0] li_addr;
  logic [LH_MAX-1:0] li_comb;
  logic              lg_comb;
  logic              pred_comb;

  assign li_comb = lhist_rd & lmask;
  assign lg_comb = lctr_rd[1];
  assign pred_comb = (gg_q == lg_comb) ? gg_q : (ch_q ? gg_q : lg_comb);

  // Address select: clear sweep, else latched indices (local counter index straight from the history read on cap_li)
  always_comb begin
    if (cmd.clear_en) begin
      g_addr  = clr_cnt[GH_MAX-1:0];
      ls_addr = clr_cnt[PC_MAX-1:0];
      li_addr = clr_cnt[LH_MAX-1:0];
    end else begin
      g_addr  = lat_gi;
      ls_addr = lat_ls;
      li_addr = cmd.cap_li ? li_comb : lat_li;
    end
  end

  // Write enables and values: zeros for the clear sweep, else the update for a train beat
  always_comb begin
    chs_we   = cmd.clear_en || (cmd.write_back && (lat_gg != lat_lg));
    gctr_we  = cmd.clear_en || cmd.write_back;
    lctr_we  = cmd.clear_en || cmd.write_back;
    lhist_we = cmd.clear_en || cmd.write_back;
    if (cmd.clear_en) begin
      chs_wd   = '0;
      gctr_wd  = '0;
      lctr_wd  = '0;
      lhist_wd = '0;
    end else begin
      chs_wd   = sat_move(chs_rd, lat_gg == outcome_q);
      gctr_wd  = sat_move(gctr_rd, outcome_q);
      lctr_wd  = sat_move(lctr_rd, outcome_q);
      lhist_wd = ((lhist_rd << 1) | LH_MAX'(outcome_q)) & lmask;
    end
  end

  tbp_ram #(.WIDTH(CTR_W), .ADDR_W(GH_MAX)) u_gctr (
    .clk(clk), .we(gctr_we), .addr(g_addr), .wdata(gctr_wd), .rdata(gctr_rd)
  );
  tbp_ram #(.WIDTH(CTR_W), .ADDR_W(GH_MAX)) u_chs (
    .clk(clk), .we(chs_we), .addr(g_addr), .wdata(chs_wd), .rdata(chs_rd)
  );
  tbp_ram #(.WIDTH(LH_MAX), .ADDR_W(PC_MAX)) u_lhist (
    .clk(clk), .we(lhist_we), .addr(ls_addr), .wdata(lhist_wd), .rdata(lhist_rd)
  );
  tbp_ram #(.WIDTH(CTR_W), .ADDR_W(LH_MAX)) u_lctr (
    .clk(clk), .we(lctr_we), .addr(li_addr), .wdata(lctr_wd), .rdata(lctr_rd)
  );

  assign sts.clear_last = &clr_cnt;
  assign sts.out_free   = !resp_valid || !resp_stall;

  // Config writes; unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      gh_bits <= GH_BITS_RST;
      lh_bits <= LH_BITS_RST;
      pc_bits <= PC_BITS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GH_BITS: gh_bits <= cfg_data;
        REG_LH_BITS: lh_bits <= cfg_data;
        REG_PC_BITS: pc_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt <= clr_cnt + CLR_W'(1);
    end
  end

  // Global history and latched indices/guesses
  always_ff @(posedge clk) begin
    if (rst) begin
      global_history <= '0;
      lat_gi         <= '0;
      lat_ls         <= '0;
      lat_li         <= '0;
      lat_gg         <= 1'b0;
      lat_lg         <= 1'b0;
    end else begin
      if (cmd.accept_pred) begin
        lat_gi <= global_history & gmask;
        lat_ls <= pc[PC_MAX-1:0] & pmask;
      end
      if (cmd.cap_li) begin
        lat_li <= li_comb;
      end
      if (cmd.load_out) begin
        lat_gg <= gg_q;
        lat_lg <= lg_comb;
      end
      if (cmd.write_back) begin
        global_history <= ((global_history << 1) | GH_MAX'(outcome_q)) & gmask;
      end
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.accept_train) outcome_q <= outcome;
    if (cmd.cap_li) begin
      gg_q <= gctr_rd[1];
      ch_q <= chs_rd[1];
    end
    if (cmd.load_out) prediction <= pred_comb;
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      resp_valid <= 1'b1;
    end else if (!resp_stall) begin
      resp_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tournament_branch_predictor.sv */
// Tournament branch predictor, top level.
// Depends on tbp_pkg, tbp_ctrl, tbp_dp, tbp_ram and the assertion macro header.
//
// Usage:
//   Request channel (req_valid/req_stall): req_type 0 = predict for pc, 1 = train
//   with outcome against the indices latched by the last predict.
//   Response channel (resp_valid/resp_stall): one prediction beat per predict,
//   none per train.
//   Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0/1/2 writes
//   global history bits, local history bits, pc index bits; other indices ignored.
// Timing:
//   A predict keeps req_stall high through S_PRD_A, S_PRD_B and S_PRD_C, a train
//   through S_TRN_RD and S_TRN_WR. The rate is set by the synchronous table
//   reads: local history, then local counter, then the result register.
// Reset:
//   rst (synchronous) starts a clear sweep over 2**max(index widths) addresses
//   (4096 at defaults) that zeroes every table; req_stall is high meanwhile.
// Stall:
//   A finished prediction waits in the output register. A train beat still
//   completes behind it; a predict beat is taken but keeps req_stall high until then.
`default_nettype none

module tournament_branch_predictor #(
  parameter int GH_MAX = tbp_pkg::GH_MAX_DEF,
  parameter int LH_MAX = tbp_pkg::LH_MAX_DEF,
  parameter int PC_MAX = tbp_pkg::PC_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic                          req_type,
  input  wire logic [31:0]                   pc,
  input  wire logic                          outcome,
  output logic                               resp_valid,
  input  wire logic                          resp_stall,
  output logic                               prediction,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tbp_pkg::CFG_W-1:0]     cfg_data
);
  import tbp_pkg::*;

  tbp_cmd_t cmd;
  tbp_sts_t sts;

  assign cfg_ready = 1'b1;

  tbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_type),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tbp_dp #(
    .GH_MAX (GH_MAX),
    .LH_MAX (LH_MAX),
    .PC_MAX (PC_MAX)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .pc         (pc),
    .outcome    (outcome),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .prediction (prediction)
  );

  // Checks
  `include "tournament_branch_predictor_assert.svh"

  `TBP_ASSERT_IMP(a_no_accept_in_clear, cmd.clear_en, req_stall)
  `TBP_ASSERT_IMP(a_load_only_when_free, cmd.load_out, sts.out_free)
  `TBP_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
  `TBP_ASSERT_IMP(a_wb_exclusive, cmd.write_back, !cmd.load_out && !cmd.clear_en)

endmodule

`default_nettype wire

/* tb/tournament_branch_predictor_tb.sv */
// Self-checking testbench for the tournament branch predictor top level.
// Keeps its own copy of the predictor tables and compares each prediction beat.
// Depends on tbp_pkg and tournament_branch_predictor.
`timescale 1ns / 100ps

module tournament_branch_predictor_tb;
  import tbp_pkg::*;

  // Request kinds on req_type
  localparam logic REQ_PREDICT = 1'b0;
  localparam logic REQ_TRAIN   = 1'b1;

  // Register index the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int GTBL_DEPTH   = 1 << GH_MAX_DEF;
  localparam int LTBL_DEPTH   = 1 << LH_MAX_DEF;
  localparam int PTBL_DEPTH   = 1 << PC_MAX_DEF;
  localparam int CFG_PAUSE    = 8;      // cycles for a train still in flight
  localparam int TAIL_CYCLES  = 32;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int PHASE_BEATS  = 270;
  localparam int N_BRANCHES   = 16;

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  logic                 req_type;
  logic [31:0]          pc;
  logic                 outcome;
  logic                 resp_valid;
  logic                 resp_stall;
  logic                 prediction;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  tournament_branch_predictor dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .pc         (pc),
    .outcome    (outcome),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .prediction (prediction),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow predictor state
  logic [CFG_W-1:0] gh_bits_sh;
  logic [CFG_W-1:0] lh_bits_sh;
  logic [CFG_W-1:0] pc_bits_sh;
  int unsigned      glob_hist_sh;
  logic [CTR_W-1:0] glob_ctr_sh [GTBL_DEPTH];
  logic [CTR_W-1:0] choice_ctr_sh [GTBL_DEPTH];
  int unsigned      local_hist_sh [PTBL_DEPTH];
  logic [CTR_W-1:0] local_ctr_sh [LTBL_DEPTH];
  int unsigned      held_gidx;
  int unsigned      held_slot;
  int unsigned      held_lidx;
  logic             held_gguess;
  logic             held_lguess;

  logic expected_dirs [$];
  logic want_dir;

  int mismatches  = 0;
  int n_checked   = 0;
  int n_trains    = 0;
  int n_cfg       = 0;

  // Idling controls
  logic gaps_on   = 1'b0;
  logic stalls_on = 1'b0;
  int   burst_left = 0;
  int   stall_len;
  logic stall_lvl;

  // Synthetic branch population for the random traffic
  logic [31:0] branch_addr [N_BRANCHES];
  int          branch_kind [N_BRANCHES];
  int          branch_trip [N_BRANCHES];
  int          branch_iter [N_BRANCHES];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Response stall pattern: runs of random length, stalled about a third of them
  initial begin
    resp_stall = 1'b0;
    forever begin
      stall_len = $urandom_range(1, 12);
      stall_lvl = stalls_on && ($urandom_range(0, 2) == 0);
      repeat (stall_len) begin
        @(negedge clk);
        resp_stall = stall_lvl;
      end
    end
  end

  // Prediction checker
  always @(posedge clk) begin
    if (!rst && resp_valid && !resp_stall) begin
      if (expected_dirs.size() == 0) begin
        $display("%0t: unexpected prediction beat, expected none, got %0b",
                 $time, prediction);
        mismatches++;
      end else begin
        want_dir = expected_dirs.pop_front();
        n_checked++;
        if (prediction !== want_dir) begin
          $display("%0t: prediction mismatch, expected %0b, got %0b",
                   $time, want_dir, prediction);
          mismatches++;
        end
      end
    end
  end

  // Active index mask; 0 behaves as 1, anything past the table width clamps
  function automatic int unsigned width_mask(input logic [CFG_W-1:0] bits, input int maxw);
    int w;
    w = bits;
    if (w < 1) w = 1;
    if (w > maxw) w = maxw;
    return (1 << w) - 1;
  endfunction

  function automatic logic [CTR_W-1:0] sat_step(input logic [CTR_W-1:0] c, input logic up);
    if (up) return (c == CTR_MAX) ? c : c + 2'd1;
    return (c == '0) ? c : c - 2'd1;
  endfunction

  task automatic clear_shadow();
    gh_bits_sh   = GH_BITS_RST;
    lh_bits_sh   = LH_BITS_RST;
    pc_bits_sh   = PC_BITS_RST;
    glob_hist_sh = 0;
    foreach (glob_ctr_sh[i]) begin
      glob_ctr_sh[i]   = '0;
      choice_ctr_sh[i] = '0;
    end
    foreach (local_hist_sh[i]) local_hist_sh[i] = 0;
    foreach (local_ctr_sh[i]) local_ctr_sh[i] = '0;
    held_gidx   = 0;
    held_slot   = 0;
    held_lidx   = 0;
    held_gguess = 1'b0;
    held_lguess = 1'b0;
  endtask

  // Look up both sides, latch the indices, return the chosen direction
  function automatic logic predict_direction(input logic [31:0] addr);
    int unsigned gi, ls, li;
    logic gg, lg;
    gi = glob_hist_sh & width_mask(gh_bits_sh, GH_MAX_DEF);
    ls = addr & width_mask(pc_bits_sh, PC_MAX_DEF);
    li = local_hist_sh[ls] & width_mask(lh_bits_sh, LH_MAX_DEF);
    gg = glob_ctr_sh[gi] >= 2;
    lg = local_ctr_sh[li] >= 2;
    held_gidx   = gi;
    held_slot   = ls;
    held_lidx   = li;
    held_gguess = gg;
    held_lguess = lg;
    if (gg != lg) return (choice_ctr_sh[gi] >= 2) ? gg : lg;
    return gg;
  endfunction

  // Apply a resolved outcome at the latched indices
  task automatic train_tables(input logic oc);
    int unsigned lmask, gmask;
    lmask = width_mask(lh_bits_sh, LH_MAX_DEF);
    gmask = width_mask(gh_bits_sh, GH_MAX_DEF);
    if (held_gguess != held_lguess)
      choice_ctr_sh[held_gidx] = sat_step(choice_ctr_sh[held_gidx], held_gguess == oc);
    glob_ctr_sh[held_gidx]  = sat_step(glob_ctr_sh[held_gidx], oc);
    local_ctr_sh[held_lidx] = sat_step(local_ctr_sh[held_lidx], oc);
    local_hist_sh[held_slot] = ((local_hist_sh[held_slot] << 1) | oc) & lmask;
    glob_hist_sh = ((glob_hist_sh << 1) | oc) & gmask;
  endtask

  // Drive one request beat at the falling edge and hold it until taken
  task automatic send_item(input logic kind, input logic [31:0] addr, input logic oc);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        req_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_valid = 1'b1;
    req_type  = kind;
    pc        = addr;
    outcome   = oc;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (kind == REQ_PREDICT) begin
      expected_dirs.push_back(predict_direction(addr));
    end else begin
      train_tables(oc);
      n_trains++;
    end
    @(negedge clk);
  endtask

  // Stop requests, let every prediction come back, then let a trailing train finish
  task automatic drain_and_idle();
    req_valid = 1'b0;
    while (expected_dirs.size() != 0) @(posedge clk);
    repeat (CFG_PAUSE) @(posedge clk);
    @(negedge clk);
  endtask

  // One config beat; caller lowers cfg_valid after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_GH_BITS: gh_bits_sh = val;
      REG_LH_BITS: lh_bits_sh = val;
      REG_PC_BITS: pc_bits_sh = val;
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] gh, lh, pcw);
    drain_and_idle();
    write_reg(REG_GH_BITS, gh);
    write_reg(REG_LH_BITS, lh);
    write_reg(REG_PC_BITS, pcw);
    cfg_valid = 1'b0;
  endtask

  // Next resolved direction for a synthetic branch
  function automatic logic next_outcome(input int k);
    branch_iter[k]++;
    case (branch_kind[k])
      0: return ($urandom_range(0, 15) != 0);             // mostly taken
      1: return ($urandom_range(0, 15) == 0);             // mostly not taken
      2: return (branch_iter[k] % branch_trip[k]) != 0;   // loop exit every trip
      default: return $urandom_range(0, 1);
    endcase
  endfunction

  task automatic new_branches();
    for (int k = 0; k < N_BRANCHES; k++) begin
      branch_addr[k] = $urandom();
      // some branches alias another in the low bits
      if (k > 0 && $urandom_range(0, 3) == 0)
        branch_addr[k][11:0] = branch_addr[k - 1][11:0];
      branch_kind[k] = $urandom_range(0, 3);
      branch_trip[k] = $urandom_range(2, 9);
      branch_iter[k] = 0;
    end
  endtask

  // Out of reset: empty tables, a train with nothing latched, extreme addresses
  task automatic test_after_reset();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_item(REQ_TRAIN, 32'h0000_0000, 1'b1);
    send_item(REQ_PREDICT, 32'h0000_0000, 1'b0);
    send_item(REQ_TRAIN, 32'hFFFF_FFFF, 1'b0);
    send_item(REQ_PREDICT, 32'hFFFF_FFFF, 1'b1);
    send_item(REQ_TRAIN, 32'h0000_0000, 1'b1);
    send_item(REQ_PREDICT, 32'hAAAA_AAAA, 1'b0);
    send_item(REQ_PREDICT, 32'h5555_5555, 1'b1);  // second predict overwrites latch
    send_item(REQ_TRAIN, 32'h1234_5678, 1'b1);
  endtask

  // Saturate counters both ways and make the two sides disagree
  task automatic test_counter_training();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    for (int i = 0; i < 4; i++) begin
      send_item(REQ_PREDICT, 32'h0000_1234, 1'b0);
      send_item(REQ_TRAIN, $urandom(), 1'b1);
    end
    for (int i = 0; i < 3; i++) begin
      send_item(REQ_PREDICT, 32'h8000_0F00, 1'b1);
      send_item(REQ_TRAIN, $urandom(), 1'b0);
    end
  endtask

  // Register limits, an undecoded index and width changes between beats
  task automatic test_register_limits();
    logic [CFG_W-1:0] settings [4][3];
    settings = '{'{4'd0, 4'd15, 4'd0}, '{4'd15, 4'd0, 4'd15},
                 '{4'd1, 4'd1, 4'd1}, '{4'd12, 4'd12, 4'd12}};
    foreach (settings[s]) begin
      set_config(settings[s][0], settings[s][1], settings[s][2]);
      for (int i = 0; i < 3; i++) begin
        send_item(REQ_PREDICT, $urandom(), 1'b0);
        send_item(REQ_TRAIN, $urandom(), $urandom_range(0, 1));
      end
    end
    drain_and_idle();
    write_reg(REG_UNUSED, 4'hF);
    cfg_valid = 1'b0;
    send_item(REQ_PREDICT, $urandom(), 1'b0);
    send_item(REQ_TRAIN, $urandom(), 1'b1);
  endtask

  // Mostly predict/train pairs from a branch population, some stray beats
  task automatic test_random_traffic();
    logic [CFG_W-1:0] settings [7][3];
    int n, pick, k;
    settings = '{'{GH_BITS_RST, LH_BITS_RST, PC_BITS_RST},
                 '{4'd1, 4'd1, 4'd1}, '{4'd12, 4'd12, 4'd12},
                 '{4'd4, 4'd7, 4'd3}, '{4'd0, 4'd15, 4'd12},
                 '{4'd0, 4'd0, 4'd0}, '{4'd15, 4'd15, 4'd15}};
    for (int s = 0; s < 7; s++) begin
      if (s >= 5) begin
        settings[s][0] = $urandom_range(0, 15);
        settings[s][1] = $urandom_range(0, 15);
        settings[s][2] = $urandom_range(0, 15);
      end
      set_config(settings[s][0], settings[s][1], settings[s][2]);
      gaps_on   = (s != 0) && ($urandom_range(0, 3) != 0);
      stalls_on = (s != 0) && ($urandom_range(0, 3) != 0);
      new_branches();
      n = 0;
      while (n < PHASE_BEATS) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          k = $urandom_range(0, N_BRANCHES - 1);
          send_item(REQ_PREDICT, branch_addr[k], $urandom_range(0, 1));
          send_item(REQ_TRAIN, $urandom(), next_outcome(k));
          n += 2;
        end else begin
          send_item(pick == 8 ? REQ_TRAIN : REQ_PREDICT, $urandom(),
                    $urandom_range(0, 1));
          n++;
        end
      end
    end
  endtask

  // Main sequence
  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req_type  = REQ_PREDICT;
    pc        = '0;
    outcome   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_GH_BITS;
    cfg_data  = '0;
    clear_shadow();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_after_reset();
    test_counter_training();
    test_register_limits();
    test_random_traffic();

    // Wait out the last predictions, bounded
    req_valid = 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && expected_dirs.size() != 0; i++) @(posedge clk);
    if (expected_dirs.size() != 0) begin
      $display("%0t: %0d predictions never returned, expected beats, got none",
               $time, expected_dirs.size());
      mismatches++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d prediction beats and %0d training beats over %0d config writes,",
             n_checked, n_trains, n_cfg);
    $display("with register limits, bursty requests and random response stalls.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("%0t: timeout waiting on a handshake", $time);
    $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/tbp_pkg.sv
rtl/core/tbp_ram.sv
rtl/core/tbp_ctrl.sv
rtl/core/tbp_dp.sv
rtl/core/tournament_branch_predictor.sv
tb/tournament_branch_predictor_tb.sv
